// ===== rtl/core/lcs_pkg.sv =====
package lcs_pkg;

  // Byte codes the filter looks at
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNone      = 8'h00;

  // Depth of the result buffer, equal to the most results one byte can cause
  localparam int unsigned OutDepth = 2;

  // Filter mode, one-hot
  typedef enum logic [5:0] {
    M_START       = 6'b000001,
    M_NORMAL      = 6'b000010,
    M_AFTER_LE    = 6'b000100,
    M_AFTER_MERGE = 6'b001000,
    M_BLANKS      = 6'b010000,
    M_COMMENT     = 6'b100000
  } mode_e;

  // One filtered result item
  typedef struct packed {
    logic [7:0] character;
    logic       end_marker;
    logic       last;
  } res_t;

  // Everything one step produces: results to push and the next state
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
    mode_e      mode;
    logic       line_end_was_cr;
  } step_t;

endpackage

// ===== rtl/core/line_join_comment_strip_filter.sv =====
// Channel   Direction  tdata                                  tuser  tlast
// s_axis    in         [7:0] byte_req                          -      end_of_text
// m_axis    out        [7:0] character, [8] end_marker, 0 pad  -      last
//
// One byte per cycle enters an input register while s_axis_tready_o is high;
// the step logic and a two-entry result buffer follow. A byte is retired when
// its results fit in the buffer; each of its results leaves as its own transfer.
// Reset puts the filter at start of text with both stages empty.
// A stall on m_axis fills the result buffer and then the input register
// before s_axis_tready_o drops.
module line_join_comment_strip_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_req
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] character, [8] end_marker
  output logic        m_axis_tlast_o    // last
);
  import lcs_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  mode_e      mode_q, mode_d;
  logic       lecr_q, lecr_d;
  step_t      step;
  logic       room;
  logic       consume;
  res_t       head;
  logic [1:0] buf_count;

  assign consume         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || consume;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eot_q  <= s_axis_tlast_i;
    end
  end

  // Filter step
  lcs_step u_step (
    .byte_i (in_byte_q),
    .eot_i  (in_eot_q),
    .mode_i (mode_q),
    .lecr_i (lecr_q),
    .step_o (step)
  );

  // Filter state, advanced when a byte retires
  assign mode_d = consume ? step.mode : mode_q;
  assign lecr_d = consume ? step.line_end_was_cr : lecr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_START;
      lecr_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      lecr_q <= lecr_d;
    end
  end

  // Result buffer
  lcs_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_q),
    .step_i  (step),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head),
    .count_o (buf_count)
  );

  assign m_axis_tdata_o = {7'd0, head.end_marker, head.character};
  assign m_axis_tlast_o = head.last;

  // Buffer never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_count <= 2'(OutDepth))
    else $error("result buffer overflow");

  // Two results from one byte only enter a buffer that is empty or empties this cycle
  a_pair_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && step.count == 2'd2) |->
      (buf_count == 2'd0 || (buf_count == 2'd1 && m_axis_tready_i)))
    else $error("result pair pushed without room");

  // The end marker closes the results of its byte and carries no character
  a_end_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[8]) |-> (m_axis_tlast_o && m_axis_tdata_o[7:0] == ChNone))
    else $error("end marker not last or not zero");

  // End of text returns the filter to start of text
  a_eot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_eot_q) |=> (mode_q == M_START && !lecr_q))
    else $error("filter did not restart after end of text");

endmodule

// ===== rtl/core/lcs_step.sv =====
module lcs_step (
  input  logic [7:0]          byte_i,
  input  logic                eot_i,
  input  lcs_pkg::mode_e      mode_i,
  input  logic                lecr_i,
  output lcs_pkg::step_t      step_o
);
  import lcs_pkg::*;

  logic is_le;
  logic is_blank;
  logic is_merge;

  assign is_le    = (byte_i == ChLf) || (byte_i == ChCr);
  assign is_blank = (byte_i == ChSpace) || (byte_i == ChTab);
  assign is_merge = (lecr_i && (byte_i == ChLf)) || (!lecr_i && (byte_i == ChCr));

  // Next mode and results for one raw byte
  always_comb begin
    step_o                 = '0;
    step_o.mode            = mode_i;
    step_o.line_end_was_cr = lecr_i;
    step_o.res0            = '{character: ChNone, end_marker: 1'b0, last: 1'b0};
    step_o.res1            = '{character: ChNone, end_marker: 1'b0, last: 1'b0};

    if (eot_i) begin
      // pending newline, then the end marker
      if ((mode_i == M_AFTER_LE) || (mode_i == M_AFTER_MERGE) || (mode_i == M_BLANKS)) begin
        step_o.count = 2'd2;
        step_o.res0  = '{character: ChLf, end_marker: 1'b0, last: 1'b0};
        step_o.res1  = '{character: ChNone, end_marker: 1'b1, last: 1'b1};
      end else begin
        step_o.count = 2'd1;
        step_o.res0  = '{character: ChNone, end_marker: 1'b1, last: 1'b1};
      end
      step_o.mode            = M_START;
      step_o.line_end_was_cr = 1'b0;
    end else begin
      case (mode_i)
        M_NORMAL: begin
          if (is_le) begin
            step_o.mode            = M_AFTER_LE;
            step_o.line_end_was_cr = (byte_i == ChCr);
          end else begin
            step_o.mode  = M_NORMAL;
            step_o.count = 2'd1;
            step_o.res0  = '{character: byte_i, end_marker: 1'b0, last: 1'b1};
          end
        end
        M_AFTER_LE, M_AFTER_MERGE, M_BLANKS: begin
          if ((mode_i == M_AFTER_LE) && is_merge) begin
            step_o.mode = M_AFTER_MERGE;
          end else if ((mode_i != M_BLANKS) && (byte_i == ChHash)) begin
            step_o.mode = M_COMMENT;
          end else if (is_blank) begin
            step_o.mode = M_BLANKS;
          end else if (byte_i == ChBackslash) begin
            // lines are joined
            step_o.mode = M_NORMAL;
          end else if (is_le) begin
            // newline for the previous line end, this one is now pending
            step_o.count           = 2'd1;
            step_o.res0            = '{character: ChLf, end_marker: 1'b0, last: 1'b1};
            step_o.mode            = M_AFTER_LE;
            step_o.line_end_was_cr = (byte_i == ChCr);
          end else begin
            step_o.count = 2'd2;
            step_o.res0  = '{character: ChLf, end_marker: 1'b0, last: 1'b0};
            step_o.res1  = '{character: byte_i, end_marker: 1'b0, last: 1'b1};
            step_o.mode  = M_NORMAL;
          end
        end
        M_COMMENT: begin
          if (is_le) begin
            step_o.mode            = M_AFTER_LE;
            step_o.line_end_was_cr = (byte_i == ChCr);
          end else begin
            step_o.mode = M_COMMENT;
          end
        end
        default: begin
          // start of text, and any code that is not a mode
          if (byte_i == ChHash) begin
            step_o.mode = M_COMMENT;
          end else if (is_le) begin
            step_o.mode            = M_AFTER_LE;
            step_o.line_end_was_cr = (byte_i == ChCr);
          end else begin
            step_o.mode  = M_NORMAL;
            step_o.count = 2'd1;
            step_o.res0  = '{character: byte_i, end_marker: 1'b0, last: 1'b1};
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/lcs_out_buf.sv =====
module lcs_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcs_pkg::step_t  step_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output lcs_pkg::res_t   head_o,
  output logic [1:0]      count_o
);
  import lcs_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  logic [1:0] cnt_pop;
  logic [1:0] free;
  logic       pop;
  res_t       ent_q [OutDepth];
  res_t       ent_d [OutDepth];

  assign pop     = valid_o && ready_i;
  assign cnt_pop = cnt_q - {1'b0, pop};
  assign free    = 2'(OutDepth) - cnt_pop;
  assign room_o  = (step_i.count <= free);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[0];
  assign count_o = cnt_q;

  // Shift out the head on a transfer, then append new results behind it
  always_comb begin
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    cnt_d    = cnt_pop;
    if (push_i && room_o) begin
      if (step_i.count != 2'd0) begin
        ent_d[cnt_pop[0]] = step_i.res0;
      end
      if (step_i.count == 2'd2) begin
        ent_d[1] = step_i.res1;
      end
      cnt_d = cnt_pop + step_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule

// ===== tb/line_join_comment_strip_filter_test.sv =====
`timescale 1ns / 1ps

module line_join_comment_strip_filter_test;
  import lcs_pkg::*;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned LongHoldAt  = 150;
  localparam int unsigned LongHoldLen = 300;
  localparam int unsigned MaxShown    = 10;

  // One raw text byte with its sender timing
  typedef struct {
    logic [7:0]  data;
    logic        eot;
    int unsigned gap;
    bit          drain;
  } text_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  text_item_t  text_q[$];
  res_t        chars_q[$];
  res_t        step_chars[$];
  mode_e       filt_mode;
  logic        filt_cr;
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned mismatches;
  int unsigned cycles;

  line_join_comment_strip_filter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Ordinary byte: a line end arms the newline logic, anything else passes
  task automatic pass_byte(input logic [7:0] b);
    if (b == ChLf || b == ChCr) begin
      filt_mode = M_AFTER_LE;
      filt_cr   = (b == ChCr);
    end else begin
      filt_mode = M_NORMAL;
      step_chars.push_back('{b, 1'b0, 1'b0});
    end
  endtask

  // Expected characters for one accepted raw byte
  task automatic filter_byte(input logic [7:0] b, input logic eot);
    logic blank;
    logic merge;
    blank = (b == ChSpace) || (b == ChTab);
    merge = (filt_cr && b == ChLf) || (!filt_cr && b == ChCr);
    step_chars.delete();
    if (eot) begin
      if (filt_mode inside {M_AFTER_LE, M_AFTER_MERGE, M_BLANKS})
        step_chars.push_back('{ChLf, 1'b0, 1'b0});
      step_chars.push_back('{ChNone, 1'b1, 1'b0});
      filt_mode = M_START;
      filt_cr   = 1'b0;
    end else begin
      case (filt_mode)
        M_START: begin
          if (b == ChHash) filt_mode = M_COMMENT;
          else pass_byte(b);
        end
        M_NORMAL: begin
          pass_byte(b);
        end
        M_AFTER_LE, M_AFTER_MERGE: begin
          if (filt_mode == M_AFTER_LE && merge) begin
            filt_mode = M_AFTER_MERGE;
          end else if (b == ChHash) begin
            filt_mode = M_COMMENT;
          end else if (blank) begin
            filt_mode = M_BLANKS;
          end else if (b == ChBackslash) begin
            filt_mode = M_NORMAL;
          end else begin
            step_chars.push_back('{ChLf, 1'b0, 1'b0});
            pass_byte(b);
          end
        end
        M_BLANKS: begin
          if (blank) begin
            filt_mode = M_BLANKS;
          end else if (b == ChBackslash) begin
            filt_mode = M_NORMAL;
          end else begin
            step_chars.push_back('{ChLf, 1'b0, 1'b0});
            pass_byte(b);
          end
        end
        default: begin
          // comment runs up to and including its line end
          if (b == ChLf || b == ChCr) begin
            filt_mode = M_AFTER_LE;
            filt_cr   = (b == ChCr);
          end
        end
      endcase
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
    foreach (step_chars[i]) chars_q.push_back(step_chars[i]);
  endtask

  // Mostly short gaps, a few long ones; none inside the busy stretch
  function automatic int unsigned pick_gap(input int unsigned idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idx >= 100 && idx < 160) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.data  = b;
    it.eot   = eot;
    it.gap   = pick_gap(n_queued);
    it.drain = (n_queued == 30) || (n_queued == 250);
    text_q.push_back(it);
    n_queued++;
  endtask

  function automatic logic [7:0] pick_line_end();
    return ($urandom_range(0, 1) != 0) ? ChCr : ChLf;
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) != 0) ? ChTab : ChSpace;
  endfunction

  // One random text construct, mostly well formed
  task automatic add_construct();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  le;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      len = $urandom_range(1, 6);
      repeat (len) add_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
    end else if (kind < 50) begin
      le = pick_line_end();
      add_byte(le, 1'b0);
      if ($urandom_range(0, 2) != 0) add_byte(pick_line_end(), 1'b0);
    end else if (kind < 60) begin
      add_byte(ChHash, 1'b0);
      len = $urandom_range(0, 5);
      repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
      add_byte(pick_line_end(), 1'b0);
    end else if (kind < 68) begin
      len = $urandom_range(1, 3);
      repeat (len) add_byte(pick_blank(), 1'b0);
      if ($urandom_range(0, 1) != 0) add_byte(ChBackslash, 1'b0);
    end else if (kind < 73) begin
      add_byte(ChBackslash, 1'b0);
    end else if (kind < 76) begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (kind < 88) begin
      add_byte(ChHash, 1'b0);
    end else begin
      len = $urandom_range(1, 4);
      repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic show_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= MaxShown)
      $display("%0t: %s: expected char %02h end %b last %b, got char %02h end %b last %b",
               $realtime, what, want.character, want.end_marker, want.last,
               got.character, got.end_marker, got.last);
  endtask

  // Sender: offers queued bytes, predicts at each accepted transfer
  text_item_t  cur_item;
  bit          have_item;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= 8'h00;
      s_tlast   <= 1'b0;
      have_item = 1'b0;
      gap_left  = 0;
      filt_mode = M_START;
      filt_cr   = 1'b0;
    end else begin
      if (s_tvalid && s_axis_tready_o) begin
        filter_byte(s_tdata, s_tlast);
        n_taken++;
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (!have_item && text_q.size() > 0) begin
          cur_item  = text_q.pop_front();
          have_item = 1'b1;
          gap_left  = cur_item.gap;
        end
        if (have_item && gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (have_item && (!cur_item.drain || chars_q.size() == 0)) begin
          s_tvalid  <= 1'b1;
          s_tdata   <= cur_item.data;
          s_tlast   <= cur_item.eot;
          have_item = 1'b0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, one stretch always ready
  int unsigned rx_hold;
  int unsigned rx_xfers;
  bit          long_hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned r;
    if (!rst_ni) begin
      m_tready       <= 1'b0;
      rx_hold        = 0;
      rx_xfers       = 0;
      long_hold_done = 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) rx_xfers++;
      if (rx_xfers == LongHoldAt && !long_hold_done) begin
        rx_hold        = LongHoldLen;
        long_hold_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_xfers >= 300 && rx_xfers < 380) begin
        m_tready <= 1'b1;
      end else if (r < 3) begin
        rx_hold  = $urandom_range(8, 40);
        m_tready <= 1'b0;
      end else begin
        m_tready <= (r >= 25);
      end
    end
  end

  // Monitor: each output transfer against the oldest expected character
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = '{m_axis_tdata_o[7:0], m_axis_tdata_o[8], m_axis_tlast_o};
      if (chars_q.size() == 0) begin
        show_mismatch("unexpected transfer", '0, got);
      end else begin
        want = chars_q.pop_front();
        if (got.character != want.character || got.end_marker != want.end_marker ||
            got.last != want.last)
          show_mismatch("mismatch", want, got);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("line_join_comment_strip_filter_test: FAIL");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    n_queued   = 0;
    n_taken    = 0;
    mismatches = 0;
    cycles     = 0;

    // comment at start of text, then a line end before a character
    add_byte(ChHash, 1'b0);
    add_byte("a", 1'b0);
    add_byte(ChLf, 1'b0);
    add_byte("A", 1'b0);
    // CR LF merge, blanks, backslash join, then hash as a plain character
    add_byte(ChCr, 1'b0);
    add_byte(ChLf, 1'b0);
    add_byte(ChSpace, 1'b0);
    add_byte(ChTab, 1'b0);
    add_byte(ChBackslash, 1'b0);
    add_byte(ChHash, 1'b0);
    // hash after blanks is plain
    add_byte(ChLf, 1'b0);
    add_byte(ChSpace, 1'b0);
    add_byte(ChHash, 1'b0);
    // line end at end of text
    add_byte(ChLf, 1'b0);
    add_byte(8'h00, 1'b1);
    // comment reaching end of text
    add_byte(ChHash, 1'b0);
    add_byte("z", 1'b0);
    add_byte(8'h5A, 1'b1);
    // backslash join at end of text
    add_byte("q", 1'b0);
    add_byte(ChLf, 1'b0);
    add_byte(ChBackslash, 1'b0);
    add_byte(8'hA5, 1'b1);
    // extreme bytes, LF CR merge, then a second CR as a new line end
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(ChLf, 1'b0);
    add_byte(ChCr, 1'b0);
    add_byte(ChCr, 1'b0);
    add_byte(8'hFF, 1'b1);

    while (n_queued < RandomItems + 28) add_construct();
    add_byte(8'($urandom_range(0, 255)), 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken < n_queued) @(negedge clk_i);
    while (chars_q.size() > 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (chars_q.size() > 0) begin
      mismatches++;
      $display("%0d expected characters never arrived", chars_q.size());
    end
    if (mismatches == 0) begin
      $display("line_join_comment_strip_filter_test: PASS");
    end else begin
      $display("line_join_comment_strip_filter_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== line_join_comment_strip_filter.f =====
rtl/core/lcs_pkg.sv
rtl/core/lcs_step.sv
rtl/core/lcs_out_buf.sv
rtl/core/line_join_comment_strip_filter.sv
tb/line_join_comment_strip_filter_test.sv
